// File: rtl/core/cds_pkg.sv
// shared types, constants and month length table for the calendar date stepper
package cds_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;

  localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
  localparam logic [YEAR_W-1:0]  YEAR_RESET = 14'd2000;
  localparam logic [MONTH_W-1:0] MONTH_MIN  = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_MAX  = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_MIN    = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_MAX    = 5'd31;

  // inverse of 25 modulo 2**14: y is a multiple of 25 exactly when
  // y * INV25 mod 2**14 stays at or below (2**14 - 1) / 25
  localparam logic [YEAR_W-1:0] INV25       = 14'd7209;
  localparam logic [YEAR_W-1:0] DIV25_LIMIT = 14'd655;

  typedef enum logic [2:0] {
    OP_SET        = 3'd0,
    OP_DAY_BACK   = 3'd1,
    OP_DAY_FWD    = 3'd2,
    OP_WEEK_BACK  = 3'd3,
    OP_WEEK_FWD   = 3'd4,
    OP_MONTH_BACK = 3'd5,
    OP_MONTH_FWD  = 3'd6,
    OP_IGNORE     = 3'd7
  } op_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd30;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/core/calendar_date_stepper.sv
// top level of the calendar date stepper: input stage, held date and result register
// Holds one Gregorian date (reset 2000-01-01) and applies one operation per input
// transaction: set date with clamping, day or week back/forward with month and year
// rollover, month back/forward with the day clipped to the new month, and an ignored
// code that reports handled = 0. Years stay within 1..9999, holding at 0001-01-01 or
// 9999-12-31. Every transaction yields exactly one result transaction carrying the
// date after the step. A transaction is registered in the input stage on entry and its
// result is registered in the result register when that stage advances; while out_tready
// does not stall the result stage, one transaction is taken every cycle. The held date
// register feeds the next operation directly, so consecutive operations need no gap.
module calendar_date_stepper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // set_year [13:0], set_month [17:14], set_day [22:18], zero [23]
  input  logic [23:0] in_tdata,
  // operation [2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // cur_year [13:0], cur_month [17:14], cur_day [22:18], zero [23]
  output logic [23:0] out_tdata,
  // handled [0]
  output logic        out_tuser
);

  logic                        s1_valid_r;
  cds_pkg::op_t                s1_op_r;
  logic [cds_pkg::YEAR_W-1:0]  s1_year_r;
  logic [cds_pkg::MONTH_W-1:0] s1_month_r;
  logic [cds_pkg::DAY_W-1:0]   s1_day_r;

  cds_pkg::date_t              held_r;
  cds_pkg::date_t              held_nxt;
  logic                        handled_nxt;

  logic                        out_valid_r;
  cds_pkg::date_t              out_date_r;
  logic                        out_handled_r;

  logic                        advance;
  logic                        in_take;

  // the result stage moves when empty or drained this cycle
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r    <= cds_pkg::op_t'(in_tuser);
      s1_year_r  <= in_tdata[13:0];
      s1_month_r <= in_tdata[17:14];
      s1_day_r   <= in_tdata[22:18];
    end
  end

  cds_next u_next (
    .op        (s1_op_r),
    .set_year  (s1_year_r),
    .set_month (s1_month_r),
    .set_day   (s1_day_r),
    .held      (held_r),
    .next_date (held_nxt),
    .handled   (handled_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '{year: cds_pkg::YEAR_RESET, month: cds_pkg::MONTH_MIN,
                       day: cds_pkg::DAY_MIN};
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        held_r <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_date_r    <= held_nxt;
      out_handled_r <= handled_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_date_r.day, out_date_r.month, out_date_r.year};
  assign out_tuser  = out_handled_r;

endmodule

// File: rtl/core/cds_leap.sv
// gregorian leap year test by the 4/100/400 rule
module cds_leap (
  input  logic [cds_pkg::YEAR_W-1:0] year,
  output logic                       leap
);

  logic [2*cds_pkg::YEAR_W-1:0] prod;
  logic                         div25;

  // divisibility by 25 through the modular inverse, no divider needed
  assign prod  = year * cds_pkg::INV25;
  assign div25 = (prod[cds_pkg::YEAR_W-1:0] <= cds_pkg::DIV25_LIMIT);

  // multiple of 4 but not of 100, or multiple of 400
  assign leap = ((year[1:0] == 2'b00) && !div25) || ((year[3:0] == 4'b0000) && div25);

endmodule

// File: rtl/core/cds_next.sv
// next held date from the current date and one operation
module cds_next (
  input  cds_pkg::op_t                op,
  input  logic [cds_pkg::YEAR_W-1:0]  set_year,
  input  logic [cds_pkg::MONTH_W-1:0] set_month,
  input  logic [cds_pkg::DAY_W-1:0]   set_day,
  input  cds_pkg::date_t              held,
  output cds_pkg::date_t              next_date,
  output logic                        handled
);

  logic [cds_pkg::YEAR_W-1:0]  year_set;
  logic [cds_pkg::MONTH_W-1:0] month_set;
  logic [cds_pkg::DAY_W-1:0]   day_set;
  logic [cds_pkg::DAY_W-1:0]   dim_set;
  logic [cds_pkg::YEAR_W-1:0]  leap_year;
  logic                        leap;

  logic [cds_pkg::MONTH_W-1:0] prev_month;
  logic [cds_pkg::MONTH_W-1:0] succ_month;
  logic                        at_first_month;
  logic                        at_last_month;
  logic                        at_first_year;
  logic                        at_last_year;
  logic [cds_pkg::DAY_W-1:0]   dim_cur;
  logic [cds_pkg::DAY_W-1:0]   dim_prev;
  logic [cds_pkg::DAY_W-1:0]   dim_succ;

  logic signed [6:0]           delta;
  logic signed [6:0]           day_sum;
  logic signed [6:0]           day_wrap;

  cds_pkg::date_t              first_date;
  cds_pkg::date_t              last_date;

  assign first_date = '{year: cds_pkg::YEAR_MIN, month: cds_pkg::MONTH_MIN,
                        day: cds_pkg::DAY_MIN};
  assign last_date  = '{year: cds_pkg::YEAR_MAX, month: cds_pkg::MONTH_MAX,
                        day: cds_pkg::DAY_MAX};

  // clamp the loaded year and month
  always_comb begin
    if (set_year < cds_pkg::YEAR_MIN) begin
      year_set = cds_pkg::YEAR_MIN;
    end else if (set_year > cds_pkg::YEAR_MAX) begin
      year_set = cds_pkg::YEAR_MAX;
    end else begin
      year_set = set_year;
    end
    if (set_month < cds_pkg::MONTH_MIN) begin
      month_set = cds_pkg::MONTH_MIN;
    end else if (set_month > cds_pkg::MONTH_MAX) begin
      month_set = cds_pkg::MONTH_MAX;
    end else begin
      month_set = set_month;
    end
  end

  // steps only see february in the held year, so one leap unit serves all
  assign leap_year = (op == cds_pkg::OP_SET) ? year_set : held.year;

  cds_leap u_leap (
    .year (leap_year),
    .leap (leap)
  );

  assign dim_set = cds_pkg::month_days(month_set, leap);

  always_comb begin
    if (set_day < cds_pkg::DAY_MIN) begin
      day_set = cds_pkg::DAY_MIN;
    end else if (set_day > dim_set) begin
      day_set = dim_set;
    end else begin
      day_set = set_day;
    end
  end

  assign at_first_month = (held.month == cds_pkg::MONTH_MIN);
  assign at_last_month  = (held.month == cds_pkg::MONTH_MAX);
  assign at_first_year  = (held.year == cds_pkg::YEAR_MIN);
  assign at_last_year   = (held.year == cds_pkg::YEAR_MAX);
  assign prev_month     = at_first_month ? cds_pkg::MONTH_MAX : held.month - 4'd1;
  assign succ_month     = at_last_month ? cds_pkg::MONTH_MIN : held.month + 4'd1;
  assign dim_cur        = cds_pkg::month_days(held.month, leap);
  assign dim_prev       = cds_pkg::month_days(prev_month, leap);
  assign dim_succ       = cds_pkg::month_days(succ_month, leap);

  always_comb begin
    case (op)
      cds_pkg::OP_DAY_BACK:  delta = -7'sd1;
      cds_pkg::OP_DAY_FWD:   delta = 7'sd1;
      cds_pkg::OP_WEEK_BACK: delta = -7'sd7;
      cds_pkg::OP_WEEK_FWD:  delta = 7'sd7;
      default:               delta = 7'sd0;
    endcase
  end

  assign day_sum = $signed({2'b00, held.day}) + delta;

  always_comb begin
    next_date = held;
    handled   = 1'b1;
    day_wrap  = 7'sd0;
    case (op)
      cds_pkg::OP_SET: begin
        next_date = '{year: year_set, month: month_set, day: day_set};
      end
      cds_pkg::OP_DAY_BACK, cds_pkg::OP_WEEK_BACK: begin
        day_wrap = day_sum + $signed({2'b00, dim_prev});
        if (day_sum < 7'sd1) begin
          if (at_first_month && at_first_year) begin
            next_date = first_date;
          end else begin
            next_date.month = prev_month;
            next_date.year  = at_first_month ? held.year - 14'd1 : held.year;
            next_date.day   = day_wrap[cds_pkg::DAY_W-1:0];
          end
        end else begin
          next_date.day = day_sum[cds_pkg::DAY_W-1:0];
        end
      end
      cds_pkg::OP_DAY_FWD, cds_pkg::OP_WEEK_FWD: begin
        day_wrap = day_sum - $signed({2'b00, dim_cur});
        if (day_sum > $signed({2'b00, dim_cur})) begin
          if (at_last_month && at_last_year) begin
            next_date = last_date;
          end else begin
            next_date.month = succ_month;
            next_date.year  = at_last_month ? held.year + 14'd1 : held.year;
            next_date.day   = day_wrap[cds_pkg::DAY_W-1:0];
          end
        end else begin
          next_date.day = day_sum[cds_pkg::DAY_W-1:0];
        end
      end
      cds_pkg::OP_MONTH_BACK: begin
        if (at_first_month && at_first_year) begin
          next_date = first_date;
        end else begin
          next_date.month = prev_month;
          next_date.year  = at_first_month ? held.year - 14'd1 : held.year;
          next_date.day   = (held.day > dim_prev) ? dim_prev : held.day;
        end
      end
      cds_pkg::OP_MONTH_FWD: begin
        if (at_last_month && at_last_year) begin
          next_date = last_date;
        end else begin
          next_date.month = succ_month;
          next_date.year  = at_last_month ? held.year + 14'd1 : held.year;
          next_date.day   = (held.day > dim_succ) ? dim_succ : held.day;
        end
      end
      default: begin
        handled = 1'b0;
      end
    endcase
  end

endmodule

// File: tb/calendar_date_stepper_tb.sv
// self-checking testbench for the calendar date stepper: directed and random date walks
module calendar_date_stepper_tb;

  typedef logic [cds_pkg::YEAR_W-1:0]  year_t;
  typedef logic [cds_pkg::MONTH_W-1:0] month_t;
  typedef logic [cds_pkg::DAY_W-1:0]   day_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam cds_pkg::date_t FIRST_DATE = '{cds_pkg::YEAR_MIN, cds_pkg::MONTH_MIN,
                                            cds_pkg::DAY_MIN};
  localparam cds_pkg::date_t LAST_DATE  = '{cds_pkg::YEAR_MAX, cds_pkg::MONTH_MAX,
                                            cds_pkg::DAY_MAX};

  typedef struct {
    cds_pkg::date_t date;
    logic           handled;
  } step_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;

  year_t       out_year;
  month_t      out_month;
  day_t        out_day;

  cds_pkg::date_t held_date = '{cds_pkg::YEAR_RESET, cds_pkg::MONTH_MIN, cds_pkg::DAY_MIN};
  step_result_t   pending_dates[$];
  int             errors = 0;
  int             stall_cycles = 0;
  bit             quiet = 1'b0;

  calendar_date_stepper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  assign out_year  = out_tdata[13:0];
  assign out_month = out_tdata[17:14];
  assign out_day   = out_tdata[22:18];

  always #10 clk = ~clk;

  function automatic bit is_leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_of_month(int y, int m);
    int lengths[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m < 1 || m > 12) return 30;
    if (m == 2 && is_leap_year(y)) return 29;
    return lengths[m-1];
  endfunction

  function automatic cds_pkg::date_t make_date(int y, int m, int d);
    cds_pkg::date_t r;
    r.year  = year_t'(y);
    r.month = month_t'(m);
    r.day   = day_t'(d);
    return r;
  endfunction

  // delta never exceeds a week, so a single month rollover is enough
  function automatic cds_pkg::date_t roll_days(cds_pkg::date_t c, int delta);
    int y, m, d;
    y = int'(c.year);
    m = int'(c.month);
    d = int'(c.day) + delta;
    if (d < 1) begin
      m--;
      if (m < 1) begin
        m = 12;
        y--;
        if (y < int'(cds_pkg::YEAR_MIN)) return FIRST_DATE;
      end
      d += days_of_month(y, m);
    end else if (d > days_of_month(y, m)) begin
      d -= days_of_month(y, m);
      m++;
      if (m > 12) begin
        m = 1;
        y++;
        if (y > int'(cds_pkg::YEAR_MAX)) return LAST_DATE;
      end
    end
    return make_date(y, m, d);
  endfunction

  function automatic cds_pkg::date_t shift_months(cds_pkg::date_t c, int delta);
    int y, m, d;
    y = int'(c.year);
    m = int'(c.month) + delta;
    d = int'(c.day);
    if (m < 1) begin
      m = 12;
      y--;
      if (y < int'(cds_pkg::YEAR_MIN)) return FIRST_DATE;
    end else if (m > 12) begin
      m = 1;
      y++;
      if (y > int'(cds_pkg::YEAR_MAX)) return LAST_DATE;
    end
    if (d > days_of_month(y, m)) d = days_of_month(y, m);
    return make_date(y, m, d);
  endfunction

  function automatic cds_pkg::date_t clamp_date(year_t sy, month_t sm, day_t sd);
    int y, m, d;
    y = int'(sy);
    m = int'(sm);
    d = int'(sd);
    if (y < int'(cds_pkg::YEAR_MIN)) y = int'(cds_pkg::YEAR_MIN);
    if (y > int'(cds_pkg::YEAR_MAX)) y = int'(cds_pkg::YEAR_MAX);
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    if (d < 1) d = 1;
    if (d > days_of_month(y, m)) d = days_of_month(y, m);
    return make_date(y, m, d);
  endfunction

  function automatic step_result_t next_date(cds_pkg::date_t c, cds_pkg::op_t op,
                                             year_t sy, month_t sm, day_t sd);
    step_result_t r;
    r.date    = c;
    r.handled = 1'b1;
    case (op)
      cds_pkg::OP_SET:        r.date = clamp_date(sy, sm, sd);
      cds_pkg::OP_DAY_BACK:   r.date = roll_days(c, -1);
      cds_pkg::OP_DAY_FWD:    r.date = roll_days(c, 1);
      cds_pkg::OP_WEEK_BACK:  r.date = roll_days(c, -7);
      cds_pkg::OP_WEEK_FWD:   r.date = roll_days(c, 7);
      cds_pkg::OP_MONTH_BACK: r.date = shift_months(c, -1);
      cds_pkg::OP_MONTH_FWD:  r.date = shift_months(c, 1);
      default:                r.handled = 1'b0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    errors++;
  endtask

  // one operation per transaction, predicted at the edge where it is taken
  task automatic send_op(cds_pkg::op_t op, year_t sy, month_t sm, day_t sd);
    int gap;
    step_result_t r;
    gap = 0;
    if (!quiet && $urandom_range(99) < 29) gap = $urandom_range(2, 1);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, sd, sm, sy};
    do @(posedge clk); while (!in_tready);
    r = next_date(held_date, op, sy, sm, sd);
    held_date = r.date;
    pending_dates.push_back(r);
  endtask

  // navigation op carrying junk in the set fields, which must not matter
  task automatic step_op(cds_pkg::op_t op);
    send_op(op, year_t'($urandom), month_t'($urandom), day_t'($urandom));
  endtask

  task automatic set_date(int y, int m, int d);
    send_op(cds_pkg::OP_SET, year_t'(y), month_t'(m), day_t'(d));
  endtask

  function automatic year_t pick_year();
    int centuries[6] = '{1600, 1700, 1900, 2000, 2100, 2400};
    case ($urandom_range(9))
      0:       return year_t'($urandom_range(3, 1));
      1:       return year_t'($urandom_range(9999, 9996));
      2:       return year_t'($urandom);
      3:       return year_t'(centuries[$urandom_range(5)] + $urandom_range(1));
      default: return year_t'($urandom_range(9999, 1));
    endcase
  endfunction

  function automatic day_t pick_day();
    if ($urandom_range(2) == 0) return day_t'($urandom_range(31, 27));
    return day_t'($urandom_range(31, 0));
  endfunction

  always @(posedge clk) out_tready <= quiet || ($urandom_range(99) >= 29);

  always @(posedge clk) begin : check_results
    step_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("result with nothing pending", int'(out_year), 0);
      end else begin
        want = pending_dates.pop_front();
        if (out_year !== want.date.year)
          report_mismatch("cur_year", int'(out_year), int'(want.date.year));
        if (out_month !== want.date.month)
          report_mismatch("cur_month", int'(out_month), int'(want.date.month));
        if (out_day !== want.date.day)
          report_mismatch("cur_day", int'(out_day), int'(want.date.day));
        if (out_tuser !== want.handled)
          report_mismatch("handled", int'(out_tuser), int'(want.handled));
      end
    end
  end

  // counts cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_reset_and_ignore();
    step_op(cds_pkg::OP_IGNORE);
    send_op(cds_pkg::OP_IGNORE, '1, '1, '1);
  endtask

  task automatic test_set_clamping();
    set_date(0, 0, 0);
    set_date(16383, 15, 31);
    set_date(2000, 2, 31);
    set_date(1900, 2, 30);
    set_date(2023, 4, 31);
  endtask

  task automatic test_day_week_rollover();
    step_op(cds_pkg::OP_DAY_FWD);
    step_op(cds_pkg::OP_DAY_BACK);
    set_date(2000, 2, 28);
    step_op(cds_pkg::OP_DAY_FWD);
    step_op(cds_pkg::OP_WEEK_FWD);
    set_date(2023, 12, 31);
    step_op(cds_pkg::OP_DAY_FWD);
    step_op(cds_pkg::OP_WEEK_BACK);
  endtask

  task automatic test_month_clip();
    set_date(2000, 1, 31);
    step_op(cds_pkg::OP_MONTH_FWD);
    step_op(cds_pkg::OP_MONTH_BACK);
  endtask

  task automatic test_year_saturation();
    set_date(1, 1, 3);
    step_op(cds_pkg::OP_WEEK_BACK);
    step_op(cds_pkg::OP_DAY_BACK);
    step_op(cds_pkg::OP_MONTH_BACK);
    set_date(9999, 12, 30);
    step_op(cds_pkg::OP_WEEK_FWD);
    step_op(cds_pkg::OP_DAY_FWD);
    set_date(9999, 12, 15);
    step_op(cds_pkg::OP_MONTH_FWD);
  endtask

  // mostly a set followed by a burst of navigation, with some raw noise
  task automatic test_random_walk(int count);
    int sent;
    int burst;
    cds_pkg::op_t op;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        step_op(cds_pkg::op_t'(3'($urandom_range(7))));
      end else begin
        send_op(cds_pkg::OP_SET, pick_year(), month_t'($urandom_range(15)), pick_day());
        burst = $urandom_range(12, 2);
        repeat (burst) begin
          op = cds_pkg::op_t'(3'($urandom_range(6, 1)));
          if ($urandom_range(19) == 0) op = cds_pkg::OP_IGNORE;
          step_op(op);
        end
        sent += burst;
      end
      sent++;
    end
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    test_random_walk(120);
    quiet = 1'b0;
  endtask

  task automatic test_pause_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_dates.size() != 0);
    step_op(cds_pkg::OP_DAY_FWD);
    step_op(cds_pkg::OP_MONTH_BACK);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_and_ignore();
    test_set_clamping();
    test_day_week_rollover();
    test_month_clip();
    test_year_saturation();
    test_random_walk(230);
    test_back_to_back();
    test_pause_until_drained();
    test_random_walk(180);
    in_tvalid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/cds_pkg.sv
rtl/core/cds_leap.sv
rtl/core/cds_next.sv
rtl/core/calendar_date_stepper.sv
tb/calendar_date_stepper_tb.sv
